FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FSSE_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define FSSE_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/fsse_pkg.sv
// ----------------------------------------------------------------------------
// fsse_pkg
// Types and constants of the frame SSE accumulator.
// ----------------------------------------------------------------------------
package fsse_pkg;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int LUMA_W   = 40;
  localparam int CHROMA_W = 38;
  localparam int SIZE_W   = 12;
  // Width wide enough for any size bound or last index over the parameter range
  localparam int CMP_W    = 15;

  // Register port
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef enum logic {
    REG_HALF_WIDTH  = 1'b0,
    REG_HALF_HEIGHT = 1'b1
  } fsse_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] src_sample;
    logic [SAMPLE_W-1:0] rec_sample;
  } fsse_in_t;

  typedef struct packed {
    logic [LUMA_W-1:0]   sse_luma;
    logic [CHROMA_W-1:0] sse_cb;
    logic [CHROMA_W-1:0] sse_cr;
  } fsse_out_t;

  // Frame size in effect, already clamped to the legal range
  typedef struct packed {
    logic [SIZE_W-1:0] half_width;
    logic [SIZE_W-1:0] half_height;
  } fsse_size_t;

endpackage

FILE: hdl/frame_sse_accumulator_top.sv
// ----------------------------------------------------------------------------
// frame_sse_accumulator_top
// Sum of squared error over a 4:2:0 frame with interleaved chroma.
//
//   channel  direction  handshake           payload
//   in       input      in_valid_i/in_stall_o    fsse_in_t  (src, rec)
//   out      output     out_valid_o/out_stall_i  fsse_out_t (luma, cb, cr)
//   cfg      input      APB psel/penable/pwrite  half_width @0, half_height @4
//
// One item per cycle is taken while the input does not stall; each item is held
// in the input register, then squared and accumulated into the state registers.
// The frame result shows on out_valid_o once the last chroma item has left the
// input register and loaded the result register.
// The input stalls only when a frame's last item meets a result not yet taken.
// Reset is asynchronous, active low, and returns the size to 1920x1080.
// ----------------------------------------------------------------------------
module frame_sse_accumulator_top
  import fsse_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fsse_in_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fsse_out_t         out_item_o
);

  fsse_size_t size;

  // Size registers
  fsse_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  // Datapath
  fsse_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: hdl/fsse_cfg.sv
// ----------------------------------------------------------------------------
// fsse_cfg
// Register port for the frame size; clamps the stored halves for use.
// ----------------------------------------------------------------------------
module fsse_cfg
  import fsse_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output fsse_size_t        size_o
);

  localparam int HwBound = MAX_WIDTH / 2;
  localparam int HhBound = MAX_HEIGHT / 2;

  logic [SIZE_W-1:0] half_width_q;
  logic [SIZE_W-1:0] half_height_q;
  logic              wr_en;
  fsse_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = fsse_reg_e'(paddr[2]);

  // Store written bits as they are
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= SIZE_W'(960);
      half_height_q <= SIZE_W'(540);
    end else if (wr_en) begin
      case (reg_sel)
        REG_HALF_WIDTH:  half_width_q  <= pwdata[SIZE_W-1:0];
        REG_HALF_HEIGHT: half_height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the stored values
  always_comb begin
    case (reg_sel)
      REG_HALF_WIDTH:  prdata = DATA_W'(half_width_q);
      REG_HALF_HEIGHT: prdata = DATA_W'(half_height_q);
      default:         prdata = '0;
    endcase
  end

  // Clamp: zero counts as one, anything above the bound takes the bound
  always_comb begin
    if (half_width_q == '0) begin
      size_o.half_width = SIZE_W'(1);
    end else if (CMP_W'(half_width_q) > CMP_W'(HwBound)) begin
      size_o.half_width = SIZE_W'(HwBound);
    end else begin
      size_o.half_width = half_width_q;
    end
    if (half_height_q == '0) begin
      size_o.half_height = SIZE_W'(1);
    end else if (CMP_W'(half_height_q) > CMP_W'(HhBound)) begin
      size_o.half_height = SIZE_W'(HhBound);
    end else begin
      size_o.half_height = half_height_q;
    end
  end

endmodule

FILE: hdl/fsse_core.sv
// ----------------------------------------------------------------------------
// fsse_core
// Input register, square-and-accumulate with raster counters, result register.
// ----------------------------------------------------------------------------
module fsse_core
  import fsse_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fsse_size_t size_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  fsse_in_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output fsse_out_t  out_item_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);

  // Input register
  logic     in_valid_q;
  fsse_in_t in_item_q;

  // Frame state
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic                chroma_q, chroma_d;
  logic [LUMA_W-1:0]   luma_q, luma_d, luma_new;
  logic [CHROMA_W-1:0] cb_q, cb_d, cb_new;
  logic [CHROMA_W-1:0] cr_q, cr_d, cr_new;

  // Result register
  logic      out_valid_q;
  fsse_out_t out_item_q;

  logic [SAMPLE_W-1:0] diff;
  logic [SQ_W-1:0]     sq;
  logic [CMP_W-1:0]    last_col, last_row;
  logic                row_end, plane_end, frame_last;
  logic                fire, accept;

  // Squared difference of the held item
  assign diff = (in_item_q.src_sample >= in_item_q.rec_sample)
              ? in_item_q.src_sample - in_item_q.rec_sample
              : in_item_q.rec_sample - in_item_q.src_sample;
  assign sq   = SQ_W'(diff) * SQ_W'(diff);

  // Row and plane ends under the size in effect now
  assign last_col  = CMP_W'({size_i.half_width, 1'b0}) - CMP_W'(1);
  assign last_row  = chroma_q ? CMP_W'(size_i.half_height) - CMP_W'(1)
                              : CMP_W'({size_i.half_height, 1'b0}) - CMP_W'(1);
  assign row_end    = CMP_W'(col_q) >= last_col;
  assign plane_end  = row_end && (CMP_W'(row_q) >= last_row);
  assign frame_last = chroma_q && plane_end;

  // Process the held item unless it closes a frame while a stalled result still waits
  assign fire       = in_valid_q && (!frame_last || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  // Accumulate into the sum picked by plane and column parity
  always_comb begin
    luma_new = luma_q;
    cb_new   = cb_q;
    cr_new   = cr_q;
    if (!chroma_q) begin
      luma_new = luma_q + LUMA_W'(sq);
    end else if (!col_q[0]) begin
      cb_new = cb_q + CHROMA_W'(sq);
    end else begin
      cr_new = cr_q + CHROMA_W'(sq);
    end
  end

  // Advance column, row and plane; clear the sums once a frame is out
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    chroma_d = chroma_q;
    luma_d   = luma_new;
    cb_d     = cb_new;
    cr_d     = cr_new;
    if (!row_end) begin
      col_d = col_q + ColW'(1);
    end else begin
      col_d = '0;
      if (!plane_end) begin
        row_d = row_q + RowW'(1);
      end else begin
        row_d    = '0;
        chroma_d = !chroma_q;
        if (chroma_q) begin
          luma_d = '0;
          cb_d   = '0;
          cr_d   = '0;
        end
      end
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  // Frame state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      chroma_q <= 1'b0;
      luma_q   <= '0;
      cb_q     <= '0;
      cr_q     <= '0;
    end else if (fire) begin
      col_q    <= col_d;
      row_q    <= row_d;
      chroma_q <= chroma_d;
      luma_q   <= luma_d;
      cb_q     <= cb_d;
      cr_q     <= cr_d;
    end
  end

  // Result register: load on frame end, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && frame_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && frame_last) begin
      out_item_q.sse_luma <= luma_new;
      out_item_q.sse_cb   <= cb_new;
      out_item_q.sse_cr   <= cr_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hdl/fsse_checker.sv
// ----------------------------------------------------------------------------
// fsse_checker
// Port-level checks of the frame SSE accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsse_checker
  import fsse_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fsse_out_t out_item_o
);

  // A stalled result stays offered
  `FSSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its sums
  `FSSE_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))

  // Input stalls only behind a held result
  `FSSE_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A fresh result follows an item accepted at the input
  `FSSE_ASSERT_IMP(a_result_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

endmodule

bind frame_sse_accumulator_top fsse_checker u_fsse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
